/* design/pdds_pkg.sv */
// Package for the packed date day stepper: field widths, command and status
// codes, the date and result types, and the leap-year and month-length rules.
// No dependencies.
`default_nettype none

package pdds_pkg;

    localparam int YEAR_W   = 20;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_NEXT = 2'd1,
        CMD_PREV = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_SAT    = 2'd2
    } status_t;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] DAYS_28   = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_29   = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_30   = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_31   = 5'd31;

    localparam logic [WDAY_W-1:0] WDAY_SUN = 3'd0;
    localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;
    localparam logic [WDAY_W-1:0] WDAY_THU = 3'd4;

    localparam logic [YEAR_W-1:0] RESET_YEAR = 20'd1970;

    // Divisibility by 25: multiply by the inverse of 25 mod 2^20 and compare
    // against floor((2^20 - 1) / 25).
    localparam logic [YEAR_W-1:0] INV25     = 20'hF5C29;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 20'd41943;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
    } date_t;

    typedef struct packed {
        date_t   date;
        status_t status;
    } res_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = y * INV25;
        div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
        // divisible by 4, and not by 100 unless by 400 (16 and 25)
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB) begin
            len = leap ? DAYS_29 : DAYS_28;
        end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
                     m == MONTH_NOV) begin
            len = DAYS_30;
        end else begin
            len = DAYS_31;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

/* design/pdds_cmd_if.sv */
// Command channel of the packed date day stepper: valid/ready plus the load
// fields. Depends on pdds_pkg.
`default_nettype none

interface pdds_cmd_if
    import pdds_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [YEAR_W-1:0]  load_year;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_day;
    logic [WDAY_W-1:0]  load_weekday;

    modport source (output valid, command, load_year, load_month, load_day,
                    load_weekday, input ready);
    modport sink   (input valid, command, load_year, load_month, load_day,
                    load_weekday, output ready);
endinterface

`default_nettype wire

/* design/pdds_date_if.sv */
// Result channel of the packed date day stepper: valid/ready plus the date
// and status. Depends on pdds_pkg.
`default_nettype none

interface pdds_date_if
    import pdds_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   weekday;
    logic [STATUS_W-1:0] status;

    modport source (output valid, year, month, day, weekday, status, input ready);
    modport sink   (input valid, year, month, day, weekday, status, output ready);
endinterface

`default_nettype wire

/* design/pdds_step.sv */
// Next-date logic: applies one load, next-day, previous-day or no-op command
// to the current date. Purely combinational. Depends on pdds_pkg.
`default_nettype none

module pdds_step
    import pdds_pkg::*;
#(
    parameter int YEAR_BITS = 20
) (
    input  cmd_t  command,
    input  date_t load,
    input  date_t cur,
    output res_t  res
);

    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'((64'd1 << YEAR_BITS) - 64'd1);

    logic             cur_leap;
    logic             load_leap;
    logic [DAY_W-1:0] cur_len;
    logic [DAY_W-1:0] prev_len;
    logic [DAY_W-1:0] load_len;
    logic             load_ok;
    logic [WDAY_W-1:0] wday_inc;
    logic [WDAY_W-1:0] wday_dec;

    assign cur_leap  = is_leap(cur.year);
    assign load_leap = is_leap(load.year);
    assign cur_len   = month_len(cur.month, cur_leap);
    assign prev_len  = month_len(cur.month - 1'b1, cur_leap);
    assign load_len  = month_len(load.month, load_leap);

    assign load_ok = (load.year <= YEAR_MAX) &&
                     (load.month >= MONTH_JAN) && (load.month <= MONTH_DEC) &&
                     (load.day >= DAY_FIRST) && (load.day <= load_len) &&
                     (load.weekday <= WDAY_SAT);

    assign wday_inc = (cur.weekday == WDAY_SAT) ? WDAY_SUN : cur.weekday + 1'b1;
    assign wday_dec = (cur.weekday == WDAY_SUN) ? WDAY_SAT : cur.weekday - 1'b1;

    always_comb
    begin
        res.date   = cur;
        res.status = ST_OK;
        unique case (command)
            CMD_LOAD:
            begin
                if (load_ok)
                begin
                    res.date = load;
                end
                else
                begin
                    res.status = ST_REJECT;
                end
            end
            CMD_NEXT:
            begin
                priority if (cur.day < cur_len)
                begin
                    res.date.day     = cur.day + 1'b1;
                    res.date.weekday = wday_inc;
                end
                else if (cur.month < MONTH_DEC)
                begin
                    res.date.month   = cur.month + 1'b1;
                    res.date.day     = DAY_FIRST;
                    res.date.weekday = wday_inc;
                end
                else if (cur.year < YEAR_MAX)
                begin
                    res.date.year    = cur.year + 1'b1;
                    res.date.month   = MONTH_JAN;
                    res.date.day     = DAY_FIRST;
                    res.date.weekday = wday_inc;
                end
                else
                begin
                    res.status = ST_SAT;
                end
            end
            CMD_PREV:
            begin
                priority if (cur.day > DAY_FIRST)
                begin
                    res.date.day     = cur.day - 1'b1;
                    res.date.weekday = wday_dec;
                end
                else if (cur.month > MONTH_JAN)
                begin
                    res.date.month   = cur.month - 1'b1;
                    res.date.day     = prev_len;
                    res.date.weekday = wday_dec;
                end
                else if (cur.year != '0)
                begin
                    res.date.year    = cur.year - 1'b1;
                    res.date.month   = MONTH_DEC;
                    res.date.day     = DAYS_31;
                    res.date.weekday = wday_dec;
                end
                else
                begin
                    res.status = ST_SAT;
                end
            end
            CMD_NONE:
            begin
                res.status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/packed_date_day_stepper_unit.sv */
// Packed date day stepper, top level. Each command transfer registers its
// result. Throughput: one command per cycle while the result side keeps up.
// A result register plus one skid entry let one more command in while a
// result waits; ready drops only when both hold results.
// Reset (rst_n low, async): date 1970-01-01 Thursday, output side empty.
// Depends on pdds_pkg, pdds_cmd_if, pdds_date_if and pdds_step.
`default_nettype none

module packed_date_day_stepper_unit
    import pdds_pkg::*;
#(
    parameter int YEAR_BITS = 20
) (
    input  wire              clk,
    input  wire              rst_n,
    pdds_cmd_if.sink         cmd,
    pdds_date_if.source      date
);

    // Current date. The year is only as wide as the configured range.
    logic [YEAR_BITS-1:0] year_reg;
    logic [MONTH_W-1:0]   month_reg;
    logic [DAY_W-1:0]     day_reg;
    logic [WDAY_W-1:0]    wday_reg;

    // Result register and skid entry.
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;

    date_t cur_date;
    date_t load_date;
    res_t  step_res;
    logic  push;
    logic  pop;

    assign cur_date.year    = YEAR_W'(year_reg);
    assign cur_date.month   = month_reg;
    assign cur_date.day     = day_reg;
    assign cur_date.weekday = wday_reg;

    assign load_date.year    = cmd.load_year;
    assign load_date.month   = cmd.load_month;
    assign load_date.day     = cmd.load_day;
    assign load_date.weekday = cmd.load_weekday;

    pdds_step #(
        .YEAR_BITS (YEAR_BITS)
    ) u_step (
        .command (cmd_t'(cmd.command)),
        .load    (load_date),
        .cur     (cur_date),
        .res     (step_res)
    );

    // Ready as long as the skid entry is free.
    assign cmd.ready = !skid_valid_reg;
    assign push      = cmd.valid && cmd.ready;
    assign pop       = out_valid_reg && date.ready;

    // Date state: updated on every command transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= YEAR_BITS'(RESET_YEAR);
            month_reg <= MONTH_JAN;
            day_reg   <= DAY_FIRST;
            wday_reg  <= WDAY_THU;
        end
        else if (push)
        begin
            year_reg  <= step_res.date.year[YEAR_BITS-1:0];
            month_reg <= step_res.date.month;
            day_reg   <= step_res.date.day;
            wday_reg  <= step_res.date.weekday;
        end
    end

    // Output queue: the skid entry refills the result register on a pop.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_next = step_res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_next       = step_res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = step_res;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign date.valid   = out_valid_reg;
    assign date.year    = out_reg.date.year;
    assign date.month   = out_reg.date.month;
    assign date.day     = out_reg.date.day;
    assign date.weekday = out_reg.date.weekday;
    assign date.status  = out_reg.status;

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without result register");

    // The stored month and weekday always stay in range and the day never drops below the first.
    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC) &&
        (day_reg >= DAY_FIRST) && (wday_reg <= WDAY_SAT))
        else $error("stored date out of range");

    // A rejected or saturated step leaves the date untouched.
    a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (step_res.status != ST_OK)) |=>
        ($stable(year_reg) && $stable(month_reg) && $stable(day_reg) &&
         $stable(wday_reg)))
        else $error("failed step changed the date");

    // A result on the port carries a month in range and a day no lower than the first.
    a_out_legal: assert property (@(posedge clk) disable iff (!rst_n)
        date.valid |-> ((date.month >= MONTH_JAN) && (date.month <= MONTH_DEC) &&
                        (date.day >= DAY_FIRST)))
        else $error("result date out of range");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Testbench for packed_date_day_stepper_unit: directed table and random commands,
// each result checked field by field against a Gregorian calendar predictor or a hand-written answer.
// Depends on pdds_pkg, pdds_cmd_if, pdds_date_if and the RTL.
`default_nettype none

module testbench
    import pdds_pkg::*;
();

    localparam int LAST_YEAR = (1 << YEAR_W) - 1;
    localparam int HOLD_OFF_CYCLES = 50;

    typedef struct {
        cmd_t               op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
    } date_cmd_t;

    typedef struct {
        date_cmd_t c;
        bit        typed;
        res_t      want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pdds_cmd_if  cmd_if ();
    pdds_date_if date_if ();

    packed_date_day_stepper_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .date  (date_if)
    );

    // Calendar state as the predictor sees it; mirrors the block's reset date.
    date_t     calendar_now;
    res_t      pending_dates[$];
    stim_row_t directed_rows[$];

    int mismatches;
    int results_seen;

    // Traffic shaping; switch_modes changes the source and sink modes only at a falling edge.
    int src_idle_pct;
    bit sink_steady;
    bit hold_req;
    int hold_left;
    bit step_back;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == MONTH_FEB)
            return leap_year(y) ? int'(DAYS_29) : int'(DAYS_28);
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return int'(DAYS_30);
        return int'(DAYS_31);
    endfunction

    // Applies one command to calendar_now and returns the answer it produces.
    function automatic res_t step_calendar(input date_cmd_t c);
        res_t r;
        int   y;
        int   m;
        int   d;
        int   w;
        y = int'(calendar_now.year);
        m = int'(calendar_now.month);
        d = int'(calendar_now.day);
        w = int'(calendar_now.weekday);
        r.status = ST_OK;
        case (c.op)
            CMD_LOAD:
            begin
                // weekday is taken as given, not checked against the date
                if (c.month < MONTH_JAN || c.month > MONTH_DEC || c.day < DAY_FIRST ||
                    int'(c.day) > days_in_month(int'(c.month), int'(c.year)) ||
                    c.weekday > WDAY_SAT)
                begin
                    r.status = ST_REJECT;
                end
                else
                begin
                    y = int'(c.year);
                    m = int'(c.month);
                    d = int'(c.day);
                    w = int'(c.weekday);
                end
            end
            CMD_NEXT:
            begin
                if (d < days_in_month(m, y))
                begin
                    d++;
                end
                else if (m < MONTH_DEC)
                begin
                    m++;
                    d = int'(DAY_FIRST);
                end
                else if (y < LAST_YEAR)
                begin
                    y++;
                    m = int'(MONTH_JAN);
                    d = int'(DAY_FIRST);
                end
                else
                begin
                    r.status = ST_SAT;
                end
                if (r.status == ST_OK)
                    w = (w + 1) % 7;
            end
            CMD_PREV:
            begin
                if (d > DAY_FIRST)
                begin
                    d--;
                end
                else if (m > MONTH_JAN)
                begin
                    m--;
                    d = days_in_month(m, y);
                end
                else if (y > 0)
                begin
                    y--;
                    m = int'(MONTH_DEC);
                    d = int'(DAYS_31);
                end
                else
                begin
                    r.status = ST_SAT;
                end
                if (r.status == ST_OK)
                    w = (w + 6) % 7;
            end
            default: ;
        endcase
        calendar_now.year    = y[YEAR_W-1:0];
        calendar_now.month   = m[MONTH_W-1:0];
        calendar_now.day     = d[DAY_W-1:0];
        calendar_now.weekday = w[WDAY_W-1:0];
        r.date = calendar_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    // Entered at a rising edge; returns at the edge where the transfer happens.
    task automatic push_cmd(input date_cmd_t c, input bit typed, input res_t want);
        res_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= c.op;
        cmd_if.load_year    <= c.year;
        cmd_if.load_month   <= c.month;
        cmd_if.load_day     <= c.day;
        cmd_if.load_weekday <= c.weekday;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        predicted = step_calendar(c);
        pending_dates.push_back(typed ? want : predicted);
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    // Mode changes happen at a falling edge so the result side never races them.
    task automatic switch_modes(input int src_pct, input bit steady, input bit hold);
        cmd_if.valid <= 1'b0;
        @(negedge clk);
        src_idle_pct = src_pct;
        sink_steady  = steady;
        if (hold)
            hold_req = 1'b1;
        @(posedge clk);
    endtask

    task automatic add_row(input cmd_t op, input int y, input int m, input int d,
                           input int w);
        stim_row_t row;
        row.c.op      = op;
        row.c.year    = y[YEAR_W-1:0];
        row.c.month   = m[MONTH_W-1:0];
        row.c.day     = d[DAY_W-1:0];
        row.c.weekday = w[WDAY_W-1:0];
        row.typed     = 1'b0;
        row.want      = '0;
        directed_rows.push_back(row);
    endtask

    // Same as add_row, with the answer written out by hand.
    task automatic add_row_typed(input cmd_t op, input int y, input int m, input int d,
                                 input int w, input int ey, input int em, input int ed,
                                 input int ew, input status_t est);
        add_row(op, y, m, d, w);
        directed_rows[$].typed             = 1'b1;
        directed_rows[$].want.date.year    = ey[YEAR_W-1:0];
        directed_rows[$].want.date.month   = em[MONTH_W-1:0];
        directed_rows[$].want.date.day     = ed[DAY_W-1:0];
        directed_rows[$].want.date.weekday = ew[WDAY_W-1:0];
        directed_rows[$].want.status       = est;
    endtask

    // Mostly runs of day steps in one direction, seeded by loads near month
    // and year ends, so rollovers happen often; the rest is junk loads and
    // the unused command.
    task automatic random_items(input int n);
        date_cmd_t c;
        int        pick;
        int        y;
        int        m;
        for (int i = 0; i < n; i++)
        begin
            pick      = $urandom_range(0, 99);
            c.year    = YEAR_W'($urandom_range(0, LAST_YEAR));
            c.month   = MONTH_W'($urandom_range(0, 15));
            c.day     = DAY_W'($urandom_range(0, 31));
            c.weekday = WDAY_W'($urandom_range(0, 7));
            if (pick < 8)
            begin
                c.op = CMD_LOAD;
                case ($urandom_range(0, 4))
                    0:       y = $urandom_range(0, 3);
                    1:       y = LAST_YEAR - $urandom_range(0, 3);
                    2:       y = $urandom_range(0, 2620) * 400 + 100 * $urandom_range(0, 3);
                    3:       y = $urandom_range(0, LAST_YEAR / 4) * 4;
                    default: y = $urandom_range(0, LAST_YEAR);
                endcase
                if ($urandom_range(0, 2) == 0)
                    m = step_back ? MONTH_JAN : MONTH_DEC;
                else
                    m = $urandom_range(MONTH_JAN, MONTH_DEC);
                c.year  = y[YEAR_W-1:0];
                c.month = m[MONTH_W-1:0];
                if ($urandom_range(0, 3) == 0)
                    c.day = DAY_W'($urandom_range(DAY_FIRST, days_in_month(m, y)));
                else if (step_back)
                    c.day = DAY_W'($urandom_range(1, 2));
                else
                    c.day = DAY_W'(days_in_month(m, y) - $urandom_range(0, 1));
                c.weekday = WDAY_W'($urandom_range(0, WDAY_SAT));
            end
            else if (pick < 14)
            begin
                c.op = CMD_LOAD;
            end
            else if (pick < 18)
            begin
                c.op = CMD_NONE;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    step_back = !step_back;
                if (step_back)
                    c.op = CMD_PREV;
                else
                    c.op = CMD_NEXT;
            end
            push_cmd(c, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    // ready is redrawn every cycle unless a hold-off or a steady stretch runs.
    initial
    begin
        date_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                date_if.ready <= 1'b0;
                hold_left--;
            end
            else if (sink_steady)
            begin
                date_if.ready <= 1'b1;
            end
            else
            begin
                date_if.ready <= ($urandom_range(0, 99) >= 28);
            end
        end
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Values sampled at the edge are the ones from before it, so no race.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && date_if.valid && date_if.ready)
        begin
            if (pending_dates.size() == 0)
            begin
                flag_mismatch("result with no command pending",
                              longint'(date_if.year), '0);
            end
            else
            begin
                want = pending_dates.pop_front();
                if (date_if.year !== want.date.year)
                    flag_mismatch("year", longint'(date_if.year),
                                  longint'(want.date.year));
                if (date_if.month !== want.date.month)
                    flag_mismatch("month", longint'(date_if.month),
                                  longint'(want.date.month));
                if (date_if.day !== want.date.day)
                    flag_mismatch("day", longint'(date_if.day),
                                  longint'(want.date.day));
                if (date_if.weekday !== want.date.weekday)
                    flag_mismatch("weekday", longint'(date_if.weekday),
                                  longint'(want.date.weekday));
                if (date_if.status !== want.status)
                    flag_mismatch("status", longint'(date_if.status),
                                  longint'(want.status));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_if.valid        = 1'b0;
        cmd_if.command      = CMD_NONE;
        cmd_if.load_year    = '0;
        cmd_if.load_month   = '0;
        cmd_if.load_day     = '0;
        cmd_if.load_weekday = '0;
        rst_n               = 1'b0;
        mismatches          = 0;
        results_seen        = 0;
        src_idle_pct        = 28;
        sink_steady         = 1'b0;
        hold_req            = 1'b0;
        hold_left           = 0;
        step_back           = 1'b0;
        calendar_now.year    = RESET_YEAR;
        calendar_now.month   = MONTH_JAN;
        calendar_now.day     = DAY_FIRST;
        calendar_now.weekday = WDAY_THU;

        // unused command right after reset shows the reset date
        add_row_typed(CMD_NONE, 0, 0, 0, 0, 1970, 1, 1, 4, ST_OK);
        add_row_typed(CMD_PREV, 0, 0, 0, 0, 1969, 12, 31, 3, ST_OK);
        // top of the year range: load, saturate, step back
        add_row_typed(CMD_LOAD, LAST_YEAR, 12, 31, 6, LAST_YEAR, 12, 31, 6, ST_OK);
        add_row_typed(CMD_NEXT, 0, 0, 0, 0, LAST_YEAR, 12, 31, 6, ST_SAT);
        add_row(CMD_PREV, 0, 0, 0, 0);
        // bottom of the year range
        add_row_typed(CMD_LOAD, 0, 1, 1, 0, 0, 1, 1, 0, ST_OK);
        add_row_typed(CMD_PREV, 0, 0, 0, 0, 0, 1, 1, 0, ST_SAT);
        add_row(CMD_NEXT, 0, 0, 0, 0);
        // rejected loads leave 0-01-02 Monday in place
        add_row_typed(CMD_LOAD, 5, 0, 10, 2, 0, 1, 2, 1, ST_REJECT);
        add_row_typed(CMD_LOAD, 5, 13, 10, 2, 0, 1, 2, 1, ST_REJECT);
        add_row_typed(CMD_LOAD, LAST_YEAR, 15, 31, 7, 0, 1, 2, 1, ST_REJECT);
        add_row_typed(CMD_LOAD, 5, 3, 0, 2, 0, 1, 2, 1, ST_REJECT);
        add_row_typed(CMD_LOAD, 5, 3, 10, 7, 0, 1, 2, 1, ST_REJECT);
        // leap-year rules: plain year, century, 400-year
        add_row(CMD_LOAD, 2023, 2, 29, 3);
        add_row(CMD_LOAD, 1900, 2, 29, 4);
        add_row(CMD_LOAD, 2000, 2, 29, 2);
        add_row(CMD_NEXT, 0, 0, 0, 0);
        add_row(CMD_PREV, 0, 0, 0, 0);
        add_row(CMD_LOAD, 1900, 2, 28, 3);
        add_row(CMD_NEXT, 0, 0, 0, 0);
        // 30-day month and year rollovers; load fields ignored on steps
        add_row(CMD_LOAD, 2024, 4, 31, 3);
        add_row(CMD_LOAD, 2024, 4, 30, 2);
        add_row(CMD_NEXT, 12345, 9, 17, 5);
        add_row(CMD_LOAD, 2001, 1, 1, 1);
        add_row(CMD_PREV, 0, 0, 0, 0);
        add_row(CMD_NEXT, 0, 0, 0, 0);
        add_row(CMD_NONE, 'hABCDE, 15, 31, 7);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

        random_items(200);

        // sender sits out until the block has answered everything
        wait_for_results();

        // result side holds off while commands keep coming: input must stall
        switch_modes(0, 1'b0, 1'b1);
        random_items(40);

        // steady stretch, no gaps on either side
        switch_modes(0, 1'b1, 1'b0);
        random_items(120);

        switch_modes(28, 1'b0, 1'b0);
        random_items(150);

        wait_for_results();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
